// ----- rtl/assert_macros.svh -----
// Assertion helpers included by field_weaken_iq_limit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

// ----- rtl/fwiq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fwiq_pkg
// Widths and configuration register indices for the field-weakening q-axis current limit.
// ---------------------------------------------------------------------------
package fwiq_pkg;
  localparam int CurW   = 15;   // current_max, rated_speed, iq_limit_pos
  localparam int MinW   = 16;   // current_min
  localparam int InW    = 16;   // id_ref, speed
  localparam int MagW   = 17;   // magnitude of a 16-bit signed value
  localparam int NegW   = 17;   // iq_limit_neg
  localparam int SqW    = 30;   // squares of current magnitudes
  localparam int IdSqW  = 31;   // square of |id_ref|, up to 2^30
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CURRENT_MAX = 2'd0,
    REG_CURRENT_MIN = 2'd1,
    REG_RATED_SPEED = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;
endpackage

// ----- rtl/fwiq_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fwiq_in_if / fwiq_out_if
// Valid/ready channels for the input items and result items.
// ---------------------------------------------------------------------------
interface fwiq_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [fwiq_pkg::InW-1:0]  id_ref;
  logic signed [fwiq_pkg::InW-1:0]  speed;
  modport source (output valid, output id_ref, output speed, input ready);
  modport sink   (input valid, input id_ref, input speed, output ready);
endinterface

interface fwiq_out_if;
  logic                             valid;
  logic                             ready;
  logic [fwiq_pkg::CurW-1:0]        iq_limit_pos;
  logic signed [fwiq_pkg::NegW-1:0] iq_limit_neg;
  modport source (output valid, output iq_limit_pos, output iq_limit_neg, input ready);
  modport sink   (input valid, input iq_limit_pos, input iq_limit_neg, output ready);
endinterface

// ----- rtl/field_weaken_iq_limit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// field_weaken_iq_limit
// Positive and negative q-axis current limits under field weakening.
// ---------------------------------------------------------------------------
// Usage:
//   in_item carries id_ref and speed; out_item returns iq_limit_pos and
//   iq_limit_neg, one result item per input item, in order.
//   Registers current_max, current_min and rated_speed are written through
//   cfg_we / cfg_index / cfg_data while no item is in flight.
//   Stages from acceptance to out_item.valid: one stage for magnitudes and
//   products, 15 restoring-division stages (one quotient bit each) for
//   current_max * rated_speed / |speed|, two stages to square the quotient and
//   pick the smaller bound, 15 square-root stages (one root bit each) and the
//   output register.
//   Throughput is one item per cycle. The whole pipeline advances together
//   whenever the output register is empty or being taken; when the receiver
//   stalls with a result waiting, every stage holds and in_item.ready drops.
//   Reset clears all valid bits and the configuration registers; nothing is in flight after.
// ---------------------------------------------------------------------------
module field_weaken_iq_limit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fwiq_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fwiq_pkg::CfgDatW-1:0]   cfg_data,
  fwiq_in_if.sink                        in_item,
  fwiq_out_if.source                     out_item
);
  localparam int CW = fwiq_pkg::CurW;
  localparam int MW = fwiq_pkg::MagW;
  localparam int SW = fwiq_pkg::SqW;
  localparam int NS = fwiq_pkg::CurW;   // division and root steps

  `include "assert_macros.svh"

  // configuration
  logic [CW-1:0]              current_max;
  logic [fwiq_pkg::MinW-1:0]  current_min;
  logic [CW-1:0]              rated_speed;
  logic [SW-1:0]              cm_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_max <= '0;
      current_min <= '0;
      rated_speed <= '0;
      cm_sq       <= '0;
    end else begin
      cm_sq <= SW'(current_max) * SW'(current_max);
      if (cfg_we) begin
        unique case (fwiq_pkg::cfg_reg_t'(cfg_index))
          fwiq_pkg::REG_CURRENT_MAX: current_max <= cfg_data[CW-1:0];
          fwiq_pkg::REG_CURRENT_MIN: current_min <= cfg_data;
          fwiq_pkg::REG_RATED_SPEED: rated_speed <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Advance every stage when the output register is empty or being taken.
  logic out_v;
  logic adv;
  assign adv = !out_v || out_item.ready;
  assign in_item.ready = adv;

  // Stage 1: magnitudes and products.
  logic [MW-1:0] id_mag, spd_mag;
  assign id_mag  = in_item.id_ref[15] ? MW'(17'h10000 - MW'(in_item.id_ref[15:0]))
                                      : MW'(in_item.id_ref[15:0]);
  assign spd_mag = in_item.speed[15]  ? MW'(17'h10000 - MW'(in_item.speed[15:0]))
                                      : MW'(in_item.speed[15:0]);

  logic                            v1, zero1, le1;
  logic [fwiq_pkg::IdSqW-1:0]      idsq1;
  logic [SW-1:0]                   numer1;
  logic [MW-1:0]                   dv1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_item.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      zero1  <= (in_item.id_ref == '0);
      le1    <= (spd_mag <= MW'(rated_speed));
      idsq1  <= fwiq_pkg::IdSqW'(id_mag) * fwiq_pkg::IdSqW'(id_mag);
      numer1 <= SW'(current_max) * SW'(rated_speed);
      dv1    <= spd_mag;
    end
  end

  // Division stages: index 0 is stage 1 seen with the top numerator half as
  // the running remainder; stage j brings in numerator bit NS-j.
  logic                         dvld  [0:NS];
  logic                         dzero [0:NS];
  logic                         dle   [0:NS];
  logic [fwiq_pkg::IdSqW-1:0]   didsq [0:NS];
  logic [SW-1:0]                dnum  [0:NS];
  logic [MW-1:0]                ddv   [0:NS];
  logic [MW-1:0]                drem  [0:NS];
  logic [CW-1:0]                dq    [0:NS];

  always_comb begin
    dvld[0]  = v1;
    dzero[0] = zero1;
    dle[0]   = le1;
    didsq[0] = idsq1;
    dnum[0]  = numer1;
    ddv[0]   = dv1;
    drem[0]  = MW'(numer1[SW-1:NS]);
    dq[0]    = '0;
  end

  for (genvar j = 1; j <= NS; j++) begin : g_div
    logic [MW:0] trial;
    logic        ge;
    assign trial = {drem[j-1], dnum[j-1][NS-j]};
    assign ge    = trial >= {1'b0, ddv[j-1]};
    always_ff @(posedge clk) begin
      if (rst) dvld[j] <= 1'b0;
      else if (adv) dvld[j] <= dvld[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dzero[j] <= dzero[j-1];
        dle[j]   <= dle[j-1];
        didsq[j] <= didsq[j-1];
        dnum[j]  <= dnum[j-1];
        ddv[j]   <= ddv[j-1];
        drem[j]  <= ge ? MW'(trial - {1'b0, ddv[j-1]}) : MW'(trial);
        dq[j]    <= {dq[j-1][CW-2:0], ge};
      end
    end
  end

  // Square the scaled magnitude; clamp max^2 - id^2 at zero.
  logic          m1v, m1zero, m1le;
  logic [SW-1:0] qsq, iqsq;
  always_ff @(posedge clk) begin
    if (rst) m1v <= 1'b0;
    else if (adv) m1v <= dvld[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1zero <= dzero[NS];
      m1le   <= dle[NS];
      qsq    <= SW'(dq[NS]) * SW'(dq[NS]);
      iqsq   <= (didsq[NS] >= fwiq_pkg::IdSqW'(cm_sq)) ? '0
              : SW'(fwiq_pkg::IdSqW'(cm_sq) - didsq[NS]);
    end
  end

  // Pick the smaller bound.
  logic          m2v, m2zero;
  logic [SW-1:0] m2val, lim;
  assign lim = m1le ? cm_sq : qsq;
  always_ff @(posedge clk) begin
    if (rst) m2v <= 1'b0;
    else if (adv) m2v <= m1v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m2zero <= m1zero;
      m2val  <= (iqsq < lim) ? iqsq : lim;
    end
  end

  // Square-root stages, two radicand bits per stage.
  logic          rvld  [0:NS];
  logic          rzero [0:NS];
  logic [SW-1:0] rval  [0:NS];
  logic [MW-1:0] rrem  [0:NS];
  logic [CW-1:0] rres  [0:NS];

  always_comb begin
    rvld[0]  = m2v;
    rzero[0] = m2zero;
    rval[0]  = m2val;
    rrem[0]  = '0;
    rres[0]  = '0;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_sqrt
    logic [MW+1:0] trial;
    logic [MW+1:0] test;
    logic          ge;
    assign trial = {rrem[k-1], rval[k-1][2*(NS-k)+1 -: 2]};
    assign test  = (MW+2)'({rres[k-1], 2'b01});
    assign ge    = trial >= test;
    always_ff @(posedge clk) begin
      if (rst) rvld[k] <= 1'b0;
      else if (adv) rvld[k] <= rvld[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rzero[k] <= rzero[k-1];
        rval[k]  <= rval[k-1];
        rrem[k]  <= ge ? MW'(trial - test) : MW'(trial);
        rres[k]  <= {rres[k-1][CW-2:0], ge};
      end
    end
  end

  // Output register; a zero d reference passes the configured limits.
  logic                    out_zero;
  logic [CW-1:0]           out_pos;
  logic [fwiq_pkg::NegW-1:0] out_neg;
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (adv) out_v <= rvld[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_zero <= rzero[NS];
      out_pos  <= rzero[NS] ? current_max : rres[NS];
      out_neg  <= rzero[NS] ? fwiq_pkg::NegW'(current_min)
                            : fwiq_pkg::NegW'(17'h0 - fwiq_pkg::NegW'(rres[NS]));
    end
  end

  assign out_item.valid        = out_v;
  assign out_item.iq_limit_pos = out_pos;
  assign out_item.iq_limit_neg = out_neg;

  // A field-weakened result is always the exact negation of its positive half.
  `ASSERT_CLK(a_neg_mirrors_pos,
    out_v && !out_zero |-> (out_neg + fwiq_pkg::NegW'(out_pos)) == '0,
    "negative limit does not mirror positive limit")
  // An accepted item lands in stage 1 on the next edge.
  `ASSERT_CLK(a_accept_enters,
    in_item.valid && in_item.ready |=> v1,
    "accepted item missing from stage 1")
  // A waiting result holds while the receiver stalls.
  `ASSERT_CLK(a_out_holds,
    out_v && !out_item.ready |=> out_v && $stable(out_pos) && $stable(out_neg),
    "stalled result changed")
endmodule

// ----- dv/field_weaken_iq_limit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// field_weaken_iq_limit testbench
// Drives id_ref / speed items through the current-limit pipeline under
// random sender bursts and receiver stalls, predicts each q-axis limit pair
// and compares it field by field with the block's output, in order.
// ---------------------------------------------------------------------------
module testbench;
  typedef struct packed {
    logic [fwiq_pkg::CurW-1:0]        pos;
    logic signed [fwiq_pkg::NegW-1:0] neg;
  } iq_limits_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  fwiq_pkg::cfg_reg_t cfg_index = fwiq_pkg::REG_CURRENT_MAX;
  logic [fwiq_pkg::CfgDatW-1:0] cfg_data = '0;

  fwiq_in_if  in_item();
  fwiq_out_if out_item();

  field_weaken_iq_limit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_item.sink), .out_item(out_item.source)
  );

  // Register mirror for the predictor.
  logic [fwiq_pkg::CurW-1:0] cur_max = '0;
  logic [fwiq_pkg::MinW-1:0] cur_min = '0;
  logic [fwiq_pkg::CurW-1:0] rated   = '0;

  iq_limits_t limits_due[$];
  int errors = 0;
  bit hold_off = 1'b0;     // receiver held off for a long stretch
  int hold_cycles = 0;
  bit stall_busy = 1'b0;   // receiver stall pattern enable

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    in_item.valid  = 1'b0;
    in_item.id_ref = '0;
    in_item.speed  = '0;
    out_item.ready = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] isqrt(input logic [31:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [16:0] mag16(input logic [15:0] raw);
    return raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
  endfunction

  // Work out the limit pair for one item from the mirrored registers.
  function automatic iq_limits_t predict_limits(input logic [15:0] id, input logic [15:0] spd);
    iq_limits_t r;
    logic [31:0] id_mag, spd_mag, scaled, bound_sq, head_sq, id_sq, root;
    if (id == 0) begin
      r.pos = cur_max;
      r.neg = {1'b0, cur_min};
      return r;
    end
    id_mag  = 32'(mag16(id));
    spd_mag = 32'(mag16(spd));
    if (spd_mag <= 32'(rated)) bound_sq = 32'(cur_max) * 32'(cur_max);
    else begin
      scaled   = (32'(cur_max) * 32'(rated)) / spd_mag;
      bound_sq = scaled * scaled;
    end
    id_sq   = id_mag * id_mag;
    head_sq = 32'(cur_max) * 32'(cur_max);
    head_sq = (id_sq >= head_sq) ? '0 : head_sq - id_sq;
    root  = isqrt(head_sq < bound_sq ? head_sq : bound_sq);
    r.pos = root[fwiq_pkg::CurW-1:0];
    r.neg = fwiq_pkg::NegW'(32'h20000 - root);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    iq_limits_t w;
    if (!rst && out_item.valid && out_item.ready) begin
      if (limits_due.size() == 0) report("unexpected item", 32'd0, 32'd0);
      else begin
        w = limits_due.pop_front();
        if (out_item.iq_limit_pos !== w.pos)
          report("iq_limit_pos", 32'(out_item.iq_limit_pos), 32'(w.pos));
        if (out_item.iq_limit_neg !== w.neg)
          report("iq_limit_neg", 32'(out_item.iq_limit_neg), 32'(w.neg));
      end
    end
  end

  // Receiver: random stall pattern, or a long counted hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) begin
      out_item.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      hold_cycles <= 0;
      out_item.ready <= stall_busy ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  task automatic write_reg(input fwiq_pkg::cfg_reg_t idx,
                           input logic [fwiq_pkg::CfgDatW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fwiq_pkg::REG_CURRENT_MAX: cur_max = val[fwiq_pkg::CurW-1:0];
      fwiq_pkg::REG_CURRENT_MIN: cur_min = val;
      fwiq_pkg::REG_RATED_SPEED: rated = val[fwiq_pkg::CurW-1:0];
      default: ;
    endcase
  endtask

  // Send one item; predict at acceptance. Leaves valid high for back-to-back.
  task automatic send_item(input logic [15:0] id, input logic [15:0] spd);
    in_item.valid  <= 1'b1;
    in_item.id_ref <= id;
    in_item.speed  <= spd;
    do @(posedge clk); while (!in_item.ready);
    limits_due.push_back(predict_limits(id, spd));
    @(negedge clk);
  endtask

  task automatic idle(input int n);
    in_item.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Wait until every result is back, then keep idling with valid low.
  task automatic drain();
    idle(1);
    while (limits_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_regs(input logic [14:0] m, input logic [15:0] n, input logic [14:0] rs);
    write_reg(fwiq_pkg::REG_CURRENT_MAX, fwiq_pkg::CfgDatW'(m));
    write_reg(fwiq_pkg::REG_CURRENT_MIN, n);
    write_reg(fwiq_pkg::REG_RATED_SPEED, fwiq_pkg::CfgDatW'(rs));
  endtask

  task automatic test_directed();
    set_regs(15'd20000, 16'hB1E0, 15'd1000);
    send_item(16'h0000, 16'h1234);     // zero d reference
    send_item(16'h0000, 16'h8000);
    send_item(16'h8000, 16'h0000);     // most negative id
    send_item(16'h7FFF, 16'h7FFF);
    send_item(16'hFFFF, 16'h8000);     // most negative speed
    send_item(16'd100, 16'd1000);      // speed at rated
    send_item(16'd100, 16'd1001);      // just above rated
    send_item(-16'sd100, -16'sd1001);
    send_item(16'd20000, 16'd10);      // difference exactly zero
    send_item(16'd20001, 16'd10);      // negative difference
    send_item(16'd1, 16'd0);
    send_item(16'd15000, 16'd3000);
    drain();
    set_regs(15'h7FFF, 16'hFFFF, 15'h7FFF);
    send_item(16'd1, 16'h8000);
    send_item(16'h8000, 16'h7FFF);
    send_item(16'h0000, 16'd5);
    send_item(16'd12345, 16'h8001);
    drain();
    set_regs(15'd0, 16'd0, 15'd0);
    send_item(16'd1, 16'd1);
    send_item(16'h0000, 16'd0);
    send_item(16'hFFFF, 16'd0);
    drain();
  endtask

  function automatic logic [15:0] rand_id();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return $urandom_range(0, 2) == 0 ? 16'h8000 : 16'h7FFF;
      2: return 16'($urandom & 32'h00FF) ^ {16{$urandom_range(0, 1) == 1}};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random(input int count);
    int left;
    left = count;
    stall_busy = 1'b1;
    while (left > 0) begin
      for (int k = $urandom_range(1, 30); k > 0 && left > 0; k--) begin
        send_item(rand_id(), 16'($urandom));
        left--;
      end
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 8));
    end
    drain();
    stall_busy = 1'b0;
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      for (int k = 0; k < 80; k++) send_item(rand_id(), 16'($urandom));
      begin
        while (hold_cycles < 120) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    set_regs(15'($urandom_range(0, 32767)), 16'($urandom), 15'($urandom_range(0, 32767)));
    test_random(300);
    test_backpressure();
    set_regs(15'h7FFF, 16'($urandom), 15'($urandom_range(0, 4000)));
    test_random(300);
    set_regs(15'($urandom_range(0, 300)), 16'($urandom), 15'h7FFF);
    test_random(250);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/fwiq_pkg.sv
rtl/fwiq_if.sv
rtl/field_weaken_iq_limit.sv
dv/field_weaken_iq_limit_tb.sv
